@@ sv/rounded_box_contain_project_macros.svh @@
// Assertion macros for the rounded box projection block.
// Included by the top level; needs clk/rst_n style signals passed in.
`ifndef ROUNDED_BOX_CONTAIN_PROJECT_MACROS_SVH
`define ROUNDED_BOX_CONTAIN_PROJECT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rbc_pkg.sv @@
// Shared types, widths and helpers for the rounded box projection block.
// No dependencies.
`default_nettype none
package rbc_pkg;

    localparam int POS_W       = 32;
    localparam int CFG_W       = 31;
    localparam int AXES        = 3;
    localparam int AX_W        = 2;
    localparam int DIM_DEFAULT = 3;
    localparam int SUM_W       = 68;
    localparam int RAD_W       = 128;
    localparam int ROOT_W      = 64;
    localparam int REM_W       = 66;
    localparam int NUM_W       = 96;
    localparam int Q_W         = 32;
    localparam int VA_W        = 33;

    typedef enum logic [1:0] {
        REG_HALF_X,
        REG_HALF_Y,
        REG_HALF_Z,
        REG_RADIUS
    } cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } pos_beat_t;

    typedef struct packed {
        logic                    inside_res;
        logic signed [POS_W-1:0] proj_x;
        logic signed [POS_W-1:0] proj_y;
        logic signed [POS_W-1:0] proj_z;
    } proj_beat_t;

    // Per-point data riding alongside the root and divide pipes.
    typedef struct packed {
        logic                              in_box;
        logic                              deep;
        logic [AXES-1:0][POS_W-1:0]        dres;
        logic [AXES-1:0][POS_W-1:0]        clamp;
        logic [AXES-1:0]                   vneg;
        logic [AXES-1:0][NUM_W-1:0]        num;
    } side_t;

    function automatic logic [POS_W-1:0] sat34(input logic signed [33:0] v);
        logic [POS_W-1:0] r;
        if (v > 34'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -34'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/rbc_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Uses rbc_pkg for widths and the side_t payload.
`default_nettype none
module rbc_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_vld,
    input  wire logic [rbc_pkg::RAD_W-1:0] in_rad,
    input  wire rbc_pkg::side_t            in_side,
    output logic                           out_vld,
    output logic [rbc_pkg::ROOT_W-1:0]     out_root,
    output rbc_pkg::side_t                 out_side
);
    import rbc_pkg::*;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W-1:0]  x_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    side_t             side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_st
        logic              vin;
        logic [RAD_W-1:0]  xin;
        logic [REM_W-1:0]  rin;
        logic [ROOT_W-1:0] qin;
        side_t             sin;
        logic [REM_W:0]    rsh;
        logic [REM_W:0]    trial;
        logic [REM_W:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign vin = in_vld;
            assign xin = in_rad;
            assign rin = '0;
            assign qin = '0;
            assign sin = in_side;
        end
        else begin : g_next
            assign vin = vld_reg[k-1];
            assign xin = x_reg[k-1];
            assign rin = rem_reg[k-1];
            assign qin = root_reg[k-1];
            assign sin = side_reg[k-1];
        end

        assign rsh   = {rin[REM_W-2:0], xin[RAD_W-1 -: 2]};
        assign trial = {1'b0, qin, 2'b01};
        assign ge    = rsh >= trial;
        assign diff  = rsh - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= {xin[RAD_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : rsh[REM_W-1:0];
                root_reg[k] <= {qin[ROOT_W-2:0], ge};
                side_reg[k] <= sin;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_side = side_reg[ROOT_W-1];

endmodule
`default_nettype wire

@@ sv/rbc_div.sv @@
// Pipelined rounded divide of three numerators by one root, 32-bit capped quotient.
// Uses rbc_pkg for widths and the side_t payload.
`default_nettype none
module rbc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_vld,
    input  wire logic [rbc_pkg::ROOT_W-1:0] in_root,
    input  wire rbc_pkg::side_t             in_side,
    output logic                            out_vld,
    output logic [rbc_pkg::AXES-1:0][rbc_pkg::Q_W-1:0] out_q,
    output rbc_pkg::side_t                  out_side
);
    import rbc_pkg::*;

    localparam int NST = Q_W + 1;

    logic                          vld_reg  [NST];
    logic [ROOT_W-1:0]             l_reg    [NST];
    logic [AXES-1:0][NUM_W-1:0]    rem_reg  [NST];
    logic [AXES-1:0][Q_W-1:0]      q_reg    [NST];
    logic [AXES-1:0]               cap_reg  [NST];
    side_t                         side_reg [NST];

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic                       vin;
        logic [ROOT_W-1:0]          lin;
        side_t                      sin;
        logic [AXES-1:0][NUM_W-1:0] rem_next;
        logic [AXES-1:0][Q_W-1:0]   q_next;
        logic [AXES-1:0]            cap_next;

        if (k == 0) begin : g_first
            // add half the divisor, then flag quotients that overflow 32 bits
            assign vin = in_vld;
            assign lin = in_root;
            assign sin = in_side;
            always_comb
            begin
                for (int l = 0; l < AXES; l++)
                begin
                    rem_next[l] = in_side.num[l] + NUM_W'(in_root[ROOT_W-1:1]);
                    cap_next[l] = rem_next[l] >= {in_root, {Q_W{1'b0}}};
                    q_next[l]   = '0;
                end
            end
        end
        else begin : g_next
            localparam int SH = Q_W - k;
            logic [NUM_W-1:0] dv;
            assign vin = vld_reg[k-1];
            assign lin = l_reg[k-1];
            assign sin = side_reg[k-1];
            assign dv  = NUM_W'(l_reg[k-1]) << SH;
            always_comb
            begin
                for (int l = 0; l < AXES; l++)
                begin
                    cap_next[l] = cap_reg[k-1][l];
                    if (rem_reg[k-1][l] >= dv)
                    begin
                        rem_next[l] = rem_reg[k-1][l] - dv;
                        q_next[l]   = {q_reg[k-1][l][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = rem_reg[k-1][l];
                        q_next[l]   = {q_reg[k-1][l][Q_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                l_reg[k]    <= lin;
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                cap_reg[k]  <= cap_next;
                side_reg[k] <= sin;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < AXES; l++)
        begin
            if (l_reg[NST-1] == '0)
                out_q[l] = '0;
            else if (cap_reg[NST-1][l])
                out_q[l] = '1;
            else
                out_q[l] = q_reg[NST-1][l];
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_side = side_reg[NST-1];

endmodule
`default_nettype wire

@@ sv/rounded_box_contain_project.sv @@
// Rounded box containment and surface projection, top level.
// Depends on rbc_pkg, rbc_sqrt, rbc_div and the assertion macro header.
//
// Usage:
//   pos channel (pos_valid/pos_ready/pos_data) takes one point per beat, Q16.16.
//   proj channel (proj_valid/proj_ready/proj_data) returns one beat per point:
//   the inside flag and the projected point, saturated to 32-bit signed.
//   cfg port writes half sizes and corner radius at any edge with cfg_we high;
//   write only while no beats are in flight.
// Timing:
//   An accepted point passes the input register, three front stages
//   (abs/clamp, squares and products, sums), 64 square root stages (one root
//   bit each), 33 divide stages (overflow check plus 32 quotient bits) and
//   the output register. Throughput is one point per cycle unless stalled.
// Stall:
//   The whole pipe advances together; when the output holds an untaken beat
//   and proj_ready is low, every stage freezes and pos_ready drops. Bubbles
//   stay where they are, so nothing is lost or repeated.
// Reset:
//   rst_n clears all valid bits and loads the default box (half size 1.0,
//   radius 0.25). There is no clearing pass.
`default_nettype none
`include "rounded_box_contain_project_macros.svh"
module rounded_box_contain_project #(
    parameter int DIMENSIONS = rbc_pkg::DIM_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pos_valid,
    output logic                           pos_ready,
    input  wire rbc_pkg::pos_beat_t        pos_data,
    output logic                           proj_valid,
    input  wire logic                      proj_ready,
    output rbc_pkg::proj_beat_t            proj_data,
    input  wire logic                      cfg_we,
    input  wire rbc_pkg::cfg_idx_t         cfg_index,
    input  wire logic [rbc_pkg::CFG_W-1:0] cfg_wdata
);
    import rbc_pkg::*;

    // ---------------- configuration ----------------
    logic [AXES-1:0][CFG_W-1:0] hs_reg;
    logic [CFG_W-1:0]           rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg  <= {AXES{31'd65536}};
            rad_reg <= 31'd16384;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_X: hs_reg[0] <= cfg_wdata;
                REG_HALF_Y: hs_reg[1] <= cfg_wdata;
                REG_HALF_Z: hs_reg[2] <= cfg_wdata;
                REG_RADIUS: rad_reg   <= cfg_wdata;
                default:    rad_reg   <= rad_reg;
            endcase
        end
    end

    // Global advance: freeze everything only when the output beat is stuck.
    logic out_vld_reg;
    logic en;
    assign en        = !out_vld_reg || proj_ready;
    assign pos_ready = en;

    // ---------------- stage A: input register ----------------
    logic      a_vld_reg;
    pos_beat_t a_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= pos_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && pos_valid)
            a_pos_reg <= pos_data;
    end

    logic [AXES-1:0][POS_W-1:0] wl;
    assign wl[0] = a_pos_reg.pos_x;
    assign wl[1] = a_pos_reg.pos_y;
    assign wl[2] = a_pos_reg.pos_z;

    // ---------------- stage B: abs, clamp, offsets ----------------
    logic [AXES-1:0]             cl_next, out_next, vneg_next;
    logic [AXES-1:0][VA_W-1:0]   va_next;
    logic [AXES-1:0][CFG_W-1:0]  sv_next;
    logic [AXES-1:0][33:0]       dist_next;
    logic [AXES-1:0][POS_W-1:0]  p_next;

    always_comb
    begin
        logic signed [32:0] wx, bb, nb, p1, p2;
        logic signed [33:0] vv, ss;
        logic [32:0]        aw;
        for (int d = 0; d < AXES; d++)
        begin
            wx = $signed({wl[d][POS_W-1], wl[d]});
            aw = wx[32] ? 33'(-wx) : wx;
            bb = $signed({2'b00, hs_reg[d]}) - $signed({2'b00, rad_reg});
            nb = -bb;
            p1 = (wx > bb) ? bb : wx;
            p2 = (p1 < nb) ? nb : p1;
            vv = $signed({wx[32], wx}) - $signed({p2[32], p2});
            ss = $signed({1'b0, aw}) + $signed({3'b000, rad_reg})
                 - $signed({3'b000, hs_reg[d]});
            p_next[d]    = p2[POS_W-1:0];
            dist_next[d] = $signed({3'b000, hs_reg[d]}) - $signed({1'b0, aw});
            if (d < DIMENSIONS)
            begin
                cl_next[d]   = (wx > bb) || (p1 < nb);
                out_next[d]  = aw > {2'b00, hs_reg[d]};
                vneg_next[d] = vv[33];
                va_next[d]   = vv[33] ? 33'(-vv) : vv[32:0];
                sv_next[d]   = (!out_next[d] && ss > 34'sd0) ? ss[CFG_W-1:0] : '0;
            end
            else
            begin
                cl_next[d]   = 1'b0;
                out_next[d]  = 1'b0;
                vneg_next[d] = 1'b0;
                va_next[d]   = '0;
                sv_next[d]   = '0;
            end
        end
    end

    logic                       b_vld_reg;
    logic [AXES-1:0][POS_W-1:0] b_w_reg, b_p_reg;
    logic [AXES-1:0]            b_cl_reg, b_out_reg, b_vneg_reg;
    logic [AXES-1:0][VA_W-1:0]  b_va_reg;
    logic [AXES-1:0][CFG_W-1:0] b_sv_reg;
    logic [AXES-1:0][33:0]      b_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_w_reg    <= wl;
            b_p_reg    <= p_next;
            b_cl_reg   <= cl_next;
            b_out_reg  <= out_next;
            b_vneg_reg <= vneg_next;
            b_va_reg   <= va_next;
            b_sv_reg   <= sv_next;
            b_dist_reg <= dist_next;
        end
    end

    // ---------------- stage C: squares, products, nearest face ----------------
    logic [AXES-1:0][2*CFG_W-1:0]  ssq_next;
    logic [AXES-1:0][2*VA_W-1:0]   vsq_next;
    logic [AXES-1:0][CFG_W+VA_W-1:0] rv_next;
    logic [AXES-1:0][POS_W-1:0]    dres_next;

    always_comb
    begin
        logic [AX_W-1:0]    best;
        logic signed [33:0] bd;
        best = '0;
        bd   = $signed(b_dist_reg[0]);
        for (int d = 1; d < AXES; d++)
        begin
            if (d < DIMENSIONS && $signed(b_dist_reg[d]) < bd)
            begin
                bd   = $signed(b_dist_reg[d]);
                best = AX_W'(d);
            end
        end
        for (int d = 0; d < AXES; d++)
        begin
            ssq_next[d] = b_sv_reg[d] * b_sv_reg[d];
            vsq_next[d] = b_va_reg[d] * b_va_reg[d];
            rv_next[d]  = rad_reg * b_va_reg[d];
            if (best == AX_W'(d))
                dres_next[d] = ($signed(b_w_reg[d]) > 32'sd0) ? {1'b0, hs_reg[d]}
                                                              : 32'd0 - {1'b0, hs_reg[d]};
            else
                dres_next[d] = b_w_reg[d];
        end
    end

    logic                            c_vld_reg;
    logic [AXES-1:0][2*CFG_W-1:0]    c_ssq_reg;
    logic [AXES-1:0][2*VA_W-1:0]     c_vsq_reg;
    logic [AXES-1:0][CFG_W+VA_W-1:0] c_rv_reg;
    logic [2*CFG_W-1:0]              c_r2_reg;
    logic                            c_deep_reg, c_inpre_reg;
    logic [AXES-1:0][POS_W-1:0]      c_dres_reg, c_p_reg;
    logic [AXES-1:0]                 c_vneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ssq_reg   <= ssq_next;
            c_vsq_reg   <= vsq_next;
            c_rv_reg    <= rv_next;
            c_r2_reg    <= rad_reg * rad_reg;
            c_deep_reg  <= ~|b_cl_reg;
            c_inpre_reg <= ~|b_out_reg;
            c_dres_reg  <= dres_next;
            c_p_reg     <= b_p_reg;
            c_vneg_reg  <= b_vneg_reg;
        end
    end

    // ---------------- stage D: sums, inside test, radicand ----------------
    logic [63:0]      sumsq;
    logic [SUM_W-1:0] ssum;
    side_t            side_next;

    always_comb
    begin
        sumsq = 64'(c_ssq_reg[0]) + 64'(c_ssq_reg[1]) + 64'(c_ssq_reg[2]);
        ssum  = SUM_W'(c_vsq_reg[0]) + SUM_W'(c_vsq_reg[1]) + SUM_W'(c_vsq_reg[2]);
        side_next.in_box = c_inpre_reg && (sumsq <= 64'(c_r2_reg));
        side_next.deep   = c_deep_reg;
        side_next.dres   = c_dres_reg;
        side_next.clamp  = c_p_reg;
        side_next.vneg   = c_vneg_reg;
        for (int d = 0; d < AXES; d++)
            side_next.num[d] = NUM_W'({c_rv_reg[d], 30'd0});
    end

    logic             d_vld_reg;
    side_t            d_side_reg;
    logic [RAD_W-1:0] d_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg <= side_next;
            d_rad_reg  <= {ssum, 60'd0};
        end
    end

    // ---------------- root and divide pipes ----------------
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    rbc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d_vld_reg),
        .in_rad   (d_rad_reg),
        .in_side  (d_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    logic                     dv_vld;
    logic [AXES-1:0][Q_W-1:0] dv_q;
    side_t                    dv_side;

    rbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld),
        .in_root  (sq_root),
        .in_side  (sq_side),
        .out_vld  (dv_vld),
        .out_q    (dv_q),
        .out_side (dv_side)
    );

    // ---------------- output register ----------------
    logic [AXES-1:0][POS_W-1:0] res;

    always_comb
    begin
        logic signed [33:0] pe, t;
        for (int d = 0; d < AXES; d++)
        begin
            pe = $signed({{2{dv_side.clamp[d][POS_W-1]}}, dv_side.clamp[d]});
            t  = dv_side.vneg[d] ? pe - $signed({2'b00, dv_q[d]})
                                 : pe + $signed({2'b00, dv_q[d]});
            if (d >= DIMENSIONS)
                res[d] = '0;
            else if (dv_side.deep)
                res[d] = dv_side.dres[d];
            else
                res[d] = sat34(t);
        end
    end

    proj_beat_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.inside_res <= dv_side.in_box;
            out_reg.proj_x     <= res[0];
            out_reg.proj_y     <= res[1];
            out_reg.proj_z     <= res[2];
        end
    end

    assign proj_valid = out_vld_reg;
    assign proj_data  = out_reg;

    // ---------------- assertions ----------------
    // a point that needs no clamp sits in the inner box, so it is inside
    `RBC_ASSERT_IMP(a_deep_inside, clk, rst_n, d_vld_reg && d_side_reg.deep,
        d_side_reg.in_box, "deep point flagged outside")
    // a zero root only comes from a zero offset on every axis
    `RBC_ASSERT_IMP(a_zero_root, clk, rst_n, sq_vld && (sq_root == '0),
        sq_side.vneg == '0, "zero root with nonzero offset")
    // unused axis reads zero
    `RBC_ASSERT_IMP(a_unused_axis, clk, rst_n, proj_valid && (DIMENSIONS < 3),
        proj_data.proj_z == '0, "unused axis not zero")
    // an accepted beat lands in the first stage
    `RBC_ASSERT_NEXT(a_accept_enters, clk, rst_n, pos_valid && pos_ready,
        a_vld_reg, "accepted beat lost at entry")

endmodule
`default_nettype wire
